// File: design/efr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efr_pkg
// types and constants shared by the edge function triangle fill block
// ----------------------------------------------------------------------------
package efr_pkg;

   localparam int COORD_W = 12;
   localparam int DELTA_W = 13;
   localparam int PROD_W  = 26;
   localparam int EDGE_W  = 28;
   localparam int SIZE_W  = 7;
   localparam int MASK_W  = 64;

   localparam logic [2:0] ADDR_WIDTH  = 3'd0;
   localparam logic [2:0] ADDR_HEIGHT = 3'd4;

   typedef struct packed {
      logic signed [COORD_W-1:0] first_x;
      logic signed [COORD_W-1:0] first_y;
      logic signed [COORD_W-1:0] second_x;
      logic signed [COORD_W-1:0] second_y;
      logic signed [COORD_W-1:0] third_x;
      logic signed [COORD_W-1:0] third_y;
      logic [31:0]               fill_rgba;
   } req_type;

   typedef struct packed {
      logic [5:0]        row_index;
      logic [MASK_W-1:0] coverage_mask;
      logic [31:0]       row_rgba;
      logic              last_row;
   } rsp_type;

   typedef struct packed {
      logic [2:0][EDGE_W-1:0]  base;
      logic [2:0][DELTA_W-1:0] dx;
      logic [2:0][DELTA_W-1:0] dy;
      logic [SIZE_W-1:0]       lo_x;
      logic [SIZE_W-1:0]       hi_x;
      logic [SIZE_W-1:0]       lo_y;
      logic [SIZE_W-1:0]       hi_y;
      logic [31:0]             rgba;
   } job_type;

endpackage
`default_nettype wire

// File: design/efr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efr_front
// takes a triangle, clips its box and sets up edge values at column zero of the box's first row
// ----------------------------------------------------------------------------
module efr_front #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  efr_pkg::req_type             req_data,
   input  wire [efr_pkg::SIZE_W-1:0]    active_width,
   input  wire [efr_pkg::SIZE_W-1:0]    active_height,
   input  wire                          q_full,
   output logic                         q_push,
   output efr_pkg::job_type             q_job
);
   import efr_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_BOX  = 2'd1;
   localparam logic [1:0] ST_MUL  = 2'd2;
   localparam logic [1:0] ST_PUSH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic signed [COORD_W-1:0] vx_ff [3], vy_ff [3];
   logic signed [COORD_W-1:0] vx_in [3], vy_in [3];
   logic signed [DELTA_W-1:0] dx_ff [3], dy_ff [3];
   logic signed [DELTA_W-1:0] dx_in [3], dy_in [3];
   logic [31:0] rgba_ff, rgba_in;
   logic [SIZE_W-1:0] lox_ff, loy_ff, hix_ff, hiy_ff;
   logic [SIZE_W-1:0] lox_in, loy_in, hix_in, hiy_in;
   logic [2:0] step_ff, step_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [EDGE_W-1:0] acc_ff [3], acc_in [3];

   logic signed [COORD_W-1:0] min_x, min_y, max_x, max_y;
   logic signed [DELTA_W-1:0] lo_x13, lo_y13, hi_x13, hi_y13, wlim, hlim;
   logic [SIZE_W-1:0] wcap, hcap;
   logic box_empty;
   logic [1:0] mul_edge, acc_edge;
   logic [2:0] step_m1;
   logic signed [DELTA_W-1:0] op_a, op_b;

   always_comb begin
      min_x = vx_ff[0] < vx_ff[1] ? vx_ff[0] : vx_ff[1];
      min_x = min_x < vx_ff[2] ? min_x : vx_ff[2];
      min_y = vy_ff[0] < vy_ff[1] ? vy_ff[0] : vy_ff[1];
      min_y = min_y < vy_ff[2] ? min_y : vy_ff[2];
      max_x = vx_ff[0] > vx_ff[1] ? vx_ff[0] : vx_ff[1];
      max_x = max_x > vx_ff[2] ? max_x : vx_ff[2];
      max_y = vy_ff[0] > vy_ff[1] ? vy_ff[0] : vy_ff[1];
      max_y = max_y > vy_ff[2] ? max_y : vy_ff[2];
      wcap = (active_width > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : active_width;
      hcap = (active_height > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : active_height;
      wlim = signed'({{(DELTA_W-SIZE_W){1'b0}}, wcap});
      hlim = signed'({{(DELTA_W-SIZE_W){1'b0}}, hcap});
      lo_x13 = min_x < 0 ? '0 : DELTA_W'(min_x);
      lo_y13 = min_y < 0 ? '0 : DELTA_W'(min_y);
      hi_x13 = DELTA_W'(max_x) > wlim ? wlim : DELTA_W'(max_x);
      hi_y13 = DELTA_W'(max_y) > hlim ? hlim : DELTA_W'(max_y);
      box_empty = (lo_x13 >= hi_x13) || (lo_y13 >= hi_y13);
   end

   always_comb begin
      mul_edge = step_ff[2:1];
      step_m1  = step_ff - 3'd1;
      acc_edge = step_m1[2:1];
      op_a = '0;
      op_b = '0;
      if (mul_edge != 2'd3) begin
         if (!step_ff[0]) begin
            op_a = signed'({{(DELTA_W-SIZE_W){1'b0}}, loy_ff}) - DELTA_W'(vy_ff[mul_edge]);
            op_b = dx_ff[mul_edge];
         end else begin
            op_a = DELTA_W'(vx_ff[mul_edge]);
            op_b = dy_ff[mul_edge];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      vx_in = vx_ff;
      vy_in = vy_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      rgba_in = rgba_ff;
      lox_in = lox_ff;
      loy_in = loy_ff;
      hix_in = hix_ff;
      hiy_in = hiy_ff;
      step_in = step_ff;
      prod_in = prod_ff;
      acc_in = acc_ff;
      q_push = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               vx_in[0] = req_data.first_x;
               vy_in[0] = req_data.first_y;
               vx_in[1] = req_data.second_x;
               vy_in[1] = req_data.second_y;
               vx_in[2] = req_data.third_x;
               vy_in[2] = req_data.third_y;
               rgba_in = req_data.fill_rgba;
               state_in = ST_BOX;
            end
         end
         ST_BOX: begin
            for (int i = 0; i < 3; i++) begin
               dx_in[i] = DELTA_W'(vx_ff[(i+1)%3]) - DELTA_W'(vx_ff[i]);
               dy_in[i] = DELTA_W'(vy_ff[(i+1)%3]) - DELTA_W'(vy_ff[i]);
               acc_in[i] = '0;
            end
            lox_in = lo_x13[SIZE_W-1:0];
            loy_in = lo_y13[SIZE_W-1:0];
            hix_in = hi_x13[SIZE_W-1:0];
            hiy_in = hi_y13[SIZE_W-1:0];
            step_in = '0;
            state_in = box_empty ? ST_IDLE : ST_MUL;
         end
         ST_MUL: begin
            prod_in = op_a * op_b;
            if (step_ff != 3'd0) begin
               acc_in[acc_edge] = acc_ff[acc_edge] + EDGE_W'(prod_ff);
            end
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd6) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (!q_full) begin
               q_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         q_job.base[i] = acc_ff[i];
         q_job.dx[i] = dx_ff[i];
         q_job.dy[i] = dy_ff[i];
      end
      q_job.lo_x = lox_ff;
      q_job.hi_x = hix_ff;
      q_job.lo_y = loy_ff;
      q_job.hi_y = hiy_ff;
      q_job.rgba = rgba_ff;
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      vx_ff <= vx_in;
      vy_ff <= vy_in;
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      rgba_ff <= rgba_in;
      lox_ff <= lox_in;
      loy_ff <= loy_in;
      hix_ff <= hix_in;
      hiy_ff <= hiy_in;
      step_ff <= step_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
   end

endmodule
`default_nettype wire

// File: design/efr_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efr_queue
// two entry queue of set-up triangles between front and back
// ----------------------------------------------------------------------------
module efr_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  efr_pkg::job_type    push_job,
   input  wire                 pop,
   output efr_pkg::job_type    head_job,
   output logic                not_empty,
   output logic                full,
   output logic [1:0]          count
);
   import efr_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] count_ff;

   assign head_job  = entry_ff[rd_ff];
   assign not_empty = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign count     = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
      if (push) entry_ff[wr_ff] <= push_job;
   end

endmodule
`default_nettype wire

// File: design/efr_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efr_back
// walks the rows of a set-up triangle and emits one coverage mask per row
// ----------------------------------------------------------------------------
module efr_back #(
   parameter int MAX_WIDTH = 64
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 q_not_empty,
   input  efr_pkg::job_type    q_job,
   output logic                q_pop,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output efr_pkg::rsp_type    rsp_data
);
   import efr_pkg::*;

   logic busy_ff, busy_in;
   logic [SIZE_W-1:0] y_ff, y_in;
   logic signed [EDGE_W-1:0] e_ff [3], e_in [3];
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic [MASK_W-1:0] mask;
   logic slot_free, last;

   for (genvar x = 0; x < MASK_W; x++) begin : g_lane
      if (x < MAX_WIDTH) begin : g_on
         localparam logic signed [SIZE_W:0] XS = (SIZE_W+1)'(x);
         logic signed [EDGE_W-1:0] xd [3];
         logic hit;
         always_comb begin
            hit = (SIZE_W'(x) >= q_job.lo_x) && (SIZE_W'(x) < q_job.hi_x);
            for (int i = 0; i < 3; i++) begin
               xd[i] = XS * signed'(q_job.dy[i]);
               if (e_ff[i] - xd[i] < 0) hit = 1'b0;
            end
         end
         assign mask[x] = hit;
      end else begin : g_off
         assign mask[x] = 1'b0;
      end
   end

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign last = (y_ff == q_job.hi_y - SIZE_W'(1));

   always_comb begin
      busy_in = busy_ff;
      y_in = y_ff;
      e_in = e_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      q_pop = 1'b0;
      if (!busy_ff) begin
         if (q_not_empty) begin
            busy_in = 1'b1;
            y_in = q_job.lo_y;
            for (int i = 0; i < 3; i++) e_in[i] = signed'(q_job.base[i]);
         end
      end else if (slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_in.row_index = y_ff[5:0];
         rsp_in.coverage_mask = mask;
         rsp_in.row_rgba = q_job.rgba;
         rsp_in.last_row = last;
         y_in = y_ff + SIZE_W'(1);
         for (int i = 0; i < 3; i++) begin
            e_in[i] = e_ff[i] + EDGE_W'(signed'(q_job.dx[i]));
         end
         if (last) begin
            busy_in = 1'b0;
            q_pop = 1'b1;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      y_ff <= y_in;
      e_ff <= e_in;
      rsp_ff <= rsp_in;
   end

endmodule
`default_nettype wire

// File: design/edge_function_triangle_fill_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edge_function_triangle_fill_top
// edge function triangle rasterizer producing one coverage mask per row
// ----------------------------------------------------------------------------
// A triangle is taken in one transfer and set up in order: accept, box clip,
// six products through one shared multiplier, a step to fold in the last
// product, then the queue push; a triangle whose clipped box is empty frees
// the input without a push and produces no transfer. Rows then leave the back
// end at one per cycle while rsp_stall is low; the back end tests all columns
// of a row at once and loads each triangle before its first row, and a two
// entry queue lets the next triangle set up while the current one is still
// emitting rows.
module edge_function_triangle_fill_top #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  efr_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output efr_pkg::rsp_type    rsp_data,
   input  wire                 psel,
   input  wire                 penable,
   input  wire                 pwrite,
   input  wire [2:0]           paddr,
   input  wire [31:0]          pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);
   import efr_pkg::*;

   logic [SIZE_W-1:0] width_ff, height_ff;
   logic q_push, q_pop, q_full, q_not_empty;
   logic [1:0] q_count;
   job_type push_job, head_job;

   assign pready = 1'b1;
   assign prdata = {25'd0, (paddr[2] ? height_ff : width_ff)};

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIZE_W'(64);
         height_ff <= SIZE_W'(64);
      end else if (psel && penable && pwrite) begin
         if ((paddr & 3'b100) == ADDR_WIDTH) width_ff <= pwdata[SIZE_W-1:0];
         if ((paddr & 3'b100) == ADDR_HEIGHT) height_ff <= pwdata[SIZE_W-1:0];
      end
   end

   efr_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .active_width(width_ff), .active_height(height_ff),
      .q_full, .q_push, .q_job(push_job)
   );

   efr_queue u_queue (
      .clock, .reset, .push(q_push), .push_job, .pop(q_pop),
      .head_job, .not_empty(q_not_empty), .full(q_full), .count(q_count)
   );

   efr_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
      .clock, .reset, .q_not_empty, .q_job(head_job), .q_pop,
      .rsp_valid, .rsp_stall, .rsp_data
   );

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count != 2'd3) else $error("queue count overflow");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_not_empty) else $error("pop from empty queue");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("push into full queue");

endmodule
`default_nettype wire
